// ----- sv/aes_pkg.sv -----
package aes_pkg;

    localparam int ByteW = 8;

    localparam logic [ByteW-1:0] BYTE_BEL   = 8'h07;
    localparam logic [ByteW-1:0] BYTE_ESC   = 8'h1B;
    localparam logic [ByteW-1:0] BYTE_ST    = 8'h9C;
    localparam logic [ByteW-1:0] BYTE_CSI   = 8'h9B;
    localparam logic [ByteW-1:0] BYTE_DCS   = 8'h90;
    localparam logic [ByteW-1:0] BYTE_OSC   = 8'h9D;
    localparam logic [ByteW-1:0] CHAR_LBRK  = 8'h5B;
    localparam logic [ByteW-1:0] CHAR_RBRK  = 8'h5D;
    localparam logic [ByteW-1:0] CHAR_SEVEN = 8'h37;
    localparam logic [ByteW-1:0] CHAR_EIGHT = 8'h38;
    localparam logic [ByteW-1:0] CHAR_P     = 8'h50;
    localparam logic [ByteW-1:0] CHAR_X     = 8'h58;
    localparam logic [ByteW-1:0] CHAR_CARET = 8'h5E;
    localparam logic [ByteW-1:0] CHAR_UNDER = 8'h5F;
    localparam logic [ByteW-1:0] CHAR_TILDE = 8'h7E;
    localparam logic [ByteW-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [ByteW-1:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [ByteW-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [ByteW-1:0] CHAR_LC_Z  = 8'h7A;

    typedef struct packed {
        logic emit;
    } parse_status_t;

endpackage

// ----- sv/aes_parser.sv -----
module aes_parser
    import aes_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [ByteW-1:0] byte_in,
    output parse_status_t    status
);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_CSI    = 3'd2,
        MODE_CURSOR = 3'd3,
        MODE_STRING = 3'd4
    } mode_t;

    mode_t mode_reg, mode_next;
    logic  echo_on_reg, echo_on_next;
    logic  is_final;
    logic  opens_string;
    logic  emit;

    always_comb begin
        is_final = ((byte_in >= CHAR_UC_A) && (byte_in <= CHAR_UC_Z)) ||
                   ((byte_in >= CHAR_LC_A) && (byte_in <= CHAR_LC_Z)) ||
                   (byte_in == CHAR_TILDE);
        opens_string = (byte_in == CHAR_P) || (byte_in == BYTE_DCS) ||
                       (byte_in == CHAR_RBRK) || (byte_in == BYTE_OSC) ||
                       (byte_in == CHAR_X) || (byte_in == CHAR_CARET) ||
                       (byte_in == CHAR_UNDER);
    end

    always_comb begin
        mode_next    = mode_reg;
        echo_on_next = echo_on_reg;
        emit         = 1'b0;
        case (mode_reg)
            MODE_ESCAPE: begin
                if ((byte_in == CHAR_LBRK) || (byte_in == BYTE_CSI)) begin
                    mode_next = MODE_CSI;
                end else if ((byte_in == CHAR_SEVEN) || (byte_in == CHAR_EIGHT)) begin
                    mode_next = MODE_CURSOR;
                end else if (opens_string) begin
                    mode_next    = MODE_STRING;
                    echo_on_next = 1'b0;
                end else begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_CSI: begin
                if (is_final) begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_CURSOR: begin
                mode_next = MODE_NORMAL;
            end
            MODE_STRING: begin
                if (byte_in == BYTE_ST) begin
                    mode_next = MODE_NORMAL;
                end
            end
            default: begin
                mode_next = MODE_NORMAL;
                if (byte_in == BYTE_BEL) begin
                    emit = 1'b0;
                end else if ((byte_in == BYTE_ST) && !echo_on_reg) begin
                    echo_on_next = 1'b1;
                end else if (byte_in == BYTE_ESC) begin
                    mode_next = MODE_ESCAPE;
                end else begin
                    emit = echo_on_reg;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_NORMAL;
            echo_on_reg <= 1'b1;
        end else if (step) begin
            mode_reg    <= mode_next;
            echo_on_reg <= echo_on_next;
        end
    end

    assign status.emit = emit;

    a_string_mutes: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_STRING) |-> !echo_on_reg)
        else $error("echo is on inside a string sequence");

    a_esc_enters_escape: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (mode_reg == MODE_NORMAL) && (byte_in == BYTE_ESC))
        |=> (mode_reg == MODE_ESCAPE))
        else $error("ESC in normal mode did not enter the escape state");

    a_emit_only_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> ((mode_reg == MODE_NORMAL) && echo_on_reg))
        else $error("text emitted outside normal mode or with echo off");

endmodule

// ----- sv/ansi_escape_stripper.sv -----
// Byte-stream filter that removes terminal control sequences and passes plain
// text. Each request carries one byte; a byte produces zero or one result.
// The block accepts one byte per cycle unless a printable byte waits on a
// stalled output: a byte is registered on input, decoded by the parser state
// machine in the next cycle, and a printable result is registered on output.
// When the output is stalled, bytes that produce no result still drain.
module ansi_escape_stripper
    import aes_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ByteW-1:0] s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [ByteW-1:0] m_tdata    // [7:0] text_byte
);

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             out_valid_reg;
    logic [ByteW-1:0] out_byte_reg;
    logic             out_free;
    logic             advance;
    parse_status_t    status;

    aes_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .byte_in (in_byte_reg),
        .status  (status)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!status.emit || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && status.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && status.emit) begin
            out_byte_reg <= in_byte_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte was lost or changed");

    a_emit_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && status.emit) |=> (out_valid_reg && (out_byte_reg == $past(in_byte_reg))))
        else $error("emitted byte did not reach the output register");

    a_stall_needs_full_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while the output could move");

endmodule
